/* design/cruise_speed_controller_unit_assert.svh */
// ---------------------------------------------------------------------------
// Cruise speed controller assertion macros
// Shorthand for the concurrent checks at the end of the top level. Each macro
// samples on clk and is disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef CRUISE_SPEED_CONTROLLER_UNIT_ASSERT_SVH
`define CRUISE_SPEED_CONTROLLER_UNIT_ASSERT_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define CSC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cruise speed controller: same-cycle check failed");

// Next-cycle implication: cons must hold in the cycle after ante.
`define CSC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cruise speed controller: next-cycle check failed");

`endif

/* design/csc_pkg.sv */
// ---------------------------------------------------------------------------
// Cruise speed controller package
// Widths, default parameter values, reset values, command codes and register indexes.
// ---------------------------------------------------------------------------
package csc_pkg;

	// Default parameter values.
	localparam int AVG_LIMIT_DEF    = 10;
	localparam int THROTTLE_TOP_DEF = 1979;

	// Fixed constants of the speed mapping and the pulse report.
	localparam int SPEED_MAX   = 80;
	localparam int REPORT_TICK = 4;

	// Field and state widths.
	localparam int CMD_W    = 3;
	localparam int ADC_W    = 12;
	localparam int SPEED_W  = 7;
	localparam int STEP_W   = 5;
	localparam int MARGIN_W = 7;
	localparam int CFG_W    = 7;
	localparam int SUM_W    = 16;
	localparam int PULSE_W  = 8;
	localparam int TICK_W   = 3;

	// Stream widths.
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 24;

	// Register reset values.
	localparam logic [STEP_W-1:0]   STEP_RST   = STEP_W'(5);
	localparam logic [MARGIN_W-1:0] MARGIN_RST = MARGIN_W'(5);

	// Input command codes; the codes 5 to 7 are ignored.
	typedef enum logic [CMD_W-1:0] {
		CMD_SAMPLE  = 3'd0,
		CMD_PIN     = 3'd1,
		CMD_TICK    = 3'd2,
		CMD_RUN_ON  = 3'd3,
		CMD_RUN_OFF = 3'd4
	} cmd_t;

	// Configuration register indexes.
	typedef enum logic {
		REG_SPEED_STEP      = 1'b0,
		REG_OVERRIDE_MARGIN = 1'b1
	} reg_idx_t;

endpackage

/* design/cruise_speed_controller_unit.sv */
// ---------------------------------------------------------------------------
// Cruise speed controller
// Throttle averaging, cruise setpoint control, button handling and speed
// pulse reporting for a motor drive, one result per input item.
// ---------------------------------------------------------------------------
// Every accepted item gives exactly one result; the block takes one item per
// clock when the output side is ready. The item is registered at the input,
// then passes the averaging stage (window sum and a reciprocal multiply by the
// window length) and the control stage (throttle to speed multiply, setpoint,
// buttons, pulse counting), each registered, into the output register. The run
// state is forwarded from the control stage to the averaging stage, so samples
// right after a run command are handled correctly. Stalls on the output side
// back up stage by stage; empty stages are filled while the output waits.
// ---------------------------------------------------------------------------
module cruise_speed_controller_unit
	import csc_pkg::*;
#(
	parameter int AVG_LIMIT    = AVG_LIMIT_DEF,
	parameter int THROTTLE_TOP = THROTTLE_TOP_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// Input stream.
	input  logic                     s_tvalid,
	output logic                     s_tready,
	// [11:0] adc_sample, [12] pulse_pin, [13] onoff_button, [14] up_button,
	// [15] down_button
	input  logic [IN_TDATA_W-1:0]    s_tdata,
	// [2:0] command
	input  logic [CMD_W-1:0]         s_tuser,
	// Output stream.
	output logic                     m_tvalid,
	input  logic                     m_tready,
	// [6:0] pwm_duty, [7] cruise_led, [8] cruise_active, [16:9] pulse_report,
	// [23:17] zero
	output logic [OUT_TDATA_W-1:0]   m_tdata,
	// [0] report_valid
	output logic                     m_tuser,
	// Configuration write port.
	input  logic                     cfg_wen,
	input  logic                     cfg_index,
	input  logic [CFG_W-1:0]         cfg_wdata
);

	// Averaging window and reciprocal constants.
	localparam int CNT_W       = $clog2(AVG_LIMIT + 1);
	localparam int AVG_DIV     = AVG_LIMIT + 1;
	localparam int AVG_SHIFT   = 20;
	localparam int AVG_RECIP_W = AVG_SHIFT;
	localparam logic [AVG_RECIP_W-1:0] AVG_RECIP =
		AVG_RECIP_W'((longint'(1) << AVG_SHIFT) / AVG_DIV + 1);
	localparam int SPD_SHIFT   = 24;
	localparam int SPD_RECIP_W = 31;
	localparam logic [SPD_RECIP_W-1:0] SPD_RECIP =
		SPD_RECIP_W'((longint'(SPEED_MAX) << SPD_SHIFT) / THROTTLE_TOP + 1);

	// Configuration registers.
	logic [STEP_W-1:0]   step_q;
	logic [MARGIN_W-1:0] margin_q;

	// Pipeline stage 1: registered input item.
	logic                 v_s1;
	logic [CMD_W-1:0]     cmd_s1;
	logic [ADC_W-1:0]     adc_s1;
	logic                 pin_s1, onoff_s1, up_s1, down_s1;

	// Pipeline stage 2: item with the throttle average it sees.
	logic                 v_s2;
	logic [CMD_W-1:0]     cmd_s2;
	logic [ADC_W-1:0]     avg_s2;
	logic                 pin_s2, onoff_s2, up_s2, down_s2;

	// Output register.
	logic                 out_v_q;
	logic [SPEED_W-1:0]   duty_q;
	logic                 led_q, active_q, rep_v_q;
	logic [PULSE_W-1:0]   rep_val_q;

	// Averaging state.
	logic [SUM_W-1:0]     sum_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [ADC_W-1:0]     avg_q;

	// Control state.
	logic [SPEED_W-1:0]   set_q;
	logic                 cruise_q, lamp_q, supp_q, running_q;
	logic                 onoff_arm_q, up_arm_q, down_arm_q, pulse_arm_q;
	logic [PULSE_W-1:0]   pcount_q, ptotal_q;
	logic [TICK_W-1:0]    ticks_q;
	logic [SPEED_W-1:0]   duty_hold_q;

	// Handshake and stage enables.
	logic out_en, s2_en, s1_en, fire1, fire2;

	assign out_en   = !out_v_q || m_tready;
	assign s2_en    = !v_s2 || out_en;
	assign s1_en    = !v_s1 || s2_en;
	assign fire1    = v_s1 && s2_en;
	assign fire2    = v_s2 && out_en;
	assign s_tready = s1_en;

	// Configuration writes; the one-bit index selects one of the two registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= STEP_RST;
			margin_q <= MARGIN_RST;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_SPEED_STEP:      step_q   <= cfg_wdata[STEP_W-1:0];
				REG_OVERRIDE_MARGIN: margin_q <= cfg_wdata[MARGIN_W-1:0];
				default: ;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s1_en) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s1_en) begin
			cmd_s1   <= s_tuser;
			adc_s1   <= s_tdata[ADC_W-1:0];
			pin_s1   <= s_tdata[12];
			onoff_s1 <= s_tdata[13];
			up_s1    <= s_tdata[14];
			down_s1  <= s_tdata[15];
		end
	end

	// Run state as left by the item in stage 2, for the averaging stage.
	logic run_fwd;

	always_comb begin
		run_fwd = running_q;
		if (v_s2) begin
			if (cmd_s2 == CMD_RUN_ON) begin
				run_fwd = 1'b1;
			end else if (cmd_s2 == CMD_RUN_OFF) begin
				run_fwd = 1'b0;
			end
		end
	end

	// Averaging stage: window sum and division by the window length.
	logic                            take_sample;
	logic [SUM_W-1:0]                sum_add;
	logic [CNT_W:0]                  cnt_inc;
	logic                            win_done;
	logic [SUM_W+AVG_RECIP_W-1:0]    avg_prod;
	logic [ADC_W-1:0]                avg_new;

	always_comb begin
		take_sample = (cmd_s1 == CMD_SAMPLE) && run_fwd;
		sum_add     = sum_q + SUM_W'(adc_s1);
		cnt_inc     = {1'b0, cnt_q} + (CNT_W+1)'(1);
		win_done    = cnt_inc > (CNT_W+1)'(AVG_LIMIT);
		avg_prod    = sum_add * AVG_RECIP;
		avg_new     = avg_q;
		if (take_sample && win_done) begin
			avg_new = avg_prod[AVG_SHIFT +: ADC_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
			avg_q <= '0;
		end else if (fire1 && take_sample) begin
			if (win_done) begin
				sum_q <= '0;
				cnt_q <= '0;
			end else begin
				sum_q <= sum_add;
				cnt_q <= cnt_inc[CNT_W-1:0];
			end
			avg_q <= avg_new;
		end
	end

	// Stage 2 register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s2_en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire1) begin
			cmd_s2   <= cmd_s1;
			avg_s2   <= avg_new;
			pin_s2   <= pin_s1;
			onoff_s2 <= onoff_s1;
			up_s2    <= up_s1;
			down_s2  <= down_s1;
		end
	end

	// Throttle speed: the clamped average times 80 over the top value.
	logic [ADC_W-1:0]             thr_clamp;
	logic [ADC_W+SPD_RECIP_W-1:0] spd_prod;
	logic [SPEED_W-1:0]           speed;

	always_comb begin
		thr_clamp = (avg_s2 > ADC_W'(THROTTLE_TOP)) ? ADC_W'(THROTTLE_TOP) : avg_s2;
		spd_prod  = thr_clamp * SPD_RECIP;
		speed     = spd_prod[SPD_SHIFT +: SPEED_W];
	end

	// Control stage: next values of the control state and the result.
	logic [SPEED_W-1:0] n_set, n_duty;
	logic               n_cruise, n_lamp, n_supp, n_run;
	logic               n_onoff_arm, n_up_arm, n_down_arm, n_pulse_arm;
	logic [PULSE_W-1:0] n_pcount, n_ptotal;
	logic [TICK_W-1:0]  n_ticks;
	logic               n_rep_v;
	logic [PULSE_W-1:0] n_rep_val;
	logic [SPEED_W:0]   up_sum, lim_sum;
	logic [STEP_W:0]    step_dbl;

	always_comb begin
		n_set       = set_q;
		n_duty      = duty_hold_q;
		n_cruise    = cruise_q;
		n_lamp      = lamp_q;
		n_supp      = supp_q;
		n_run       = running_q;
		n_onoff_arm = onoff_arm_q;
		n_up_arm    = up_arm_q;
		n_down_arm  = down_arm_q;
		n_pulse_arm = pulse_arm_q;
		n_pcount    = pcount_q;
		n_ptotal    = ptotal_q;
		n_ticks     = ticks_q;
		n_rep_v     = 1'b0;
		n_rep_val   = '0;
		up_sum      = '0;
		step_dbl    = {step_q, 1'b0};
		lim_sum     = {1'b0, set_q} + (SPEED_W+1)'(margin_q);

		unique case (cmd_s2)
			CMD_SAMPLE: begin
				// Setpoint follows the throttle, or a high throttle cancels cruise.
				if (running_q) begin
					if (!cruise_q) begin
						n_set = speed;
					end else if ({1'b0, speed} > lim_sum) begin
						n_cruise = 1'b0;
						n_lamp   = 1'b0;
					end
					n_duty = n_set;
				end
			end
			CMD_PIN: begin
				// Speed pulse edge.
				if (pin_s2) begin
					if (pulse_arm_q) begin
						n_pulse_arm = 1'b0;
						n_pcount    = pcount_q + PULSE_W'(1);
					end
				end else begin
					n_pulse_arm = 1'b1;
				end
				// On/off button toggles cruise and latches the setpoint.
				if (onoff_s2) begin
					if (onoff_arm_q) begin
						n_onoff_arm = 1'b0;
						if (cruise_q) begin
							n_cruise = 1'b0;
							n_lamp   = 1'b0;
						end else begin
							n_cruise = 1'b1;
							n_lamp   = !supp_q;
							n_set    = speed;
						end
					end
				end else begin
					n_onoff_arm = 1'b1;
				end
				// Up and down buttons move the setpoint while cruise holds.
				if (n_cruise) begin
					if (up_s2) begin
						if (up_arm_q) begin
							n_up_arm = 1'b0;
							up_sum   = {1'b0, n_set} + (SPEED_W+1)'(step_q);
							if (up_sum > (SPEED_W+1)'(SPEED_MAX)) begin
								n_set = SPEED_W'(SPEED_MAX);
							end else begin
								n_set = up_sum[SPEED_W-1:0];
							end
						end
					end else begin
						n_up_arm = 1'b1;
					end
					if (down_s2) begin
						if (down_arm_q) begin
							n_down_arm = 1'b0;
							if (n_set < SPEED_W'(step_dbl)) begin
								n_set = '0;
							end else begin
								n_set = n_set - SPEED_W'(step_q);
							end
						end
					end else begin
						n_down_arm = 1'b1;
					end
				end
			end
			CMD_TICK: begin
				// Fold the pulse count into the total, report every fourth tick.
				n_ptotal = ptotal_q + pcount_q;
				n_pcount = '0;
				n_ticks  = ticks_q + TICK_W'(1);
				if (running_q && n_ticks == TICK_W'(REPORT_TICK)) begin
					n_rep_v   = 1'b1;
					n_rep_val = n_ptotal;
					n_ticks   = '0;
					n_ptotal  = '0;
				end else if (n_ticks > TICK_W'(REPORT_TICK)) begin
					n_ticks  = '0;
					n_ptotal = '0;
				end
			end
			CMD_RUN_ON: begin
				n_run  = 1'b1;
				n_supp = 1'b0;
			end
			CMD_RUN_OFF: begin
				n_run = 1'b0;
			end
			default: ;
		endcase

		// Held idle while not running.
		if (!n_run) begin
			n_supp   = 1'b1;
			n_duty   = '0;
			n_lamp   = 1'b0;
			n_set    = '0;
			n_ptotal = '0;
			n_ticks  = '0;
			n_cruise = 1'b0;
		end
	end

	// Control state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_q       <= '0;
			duty_hold_q <= '0;
			cruise_q    <= 1'b0;
			lamp_q      <= 1'b0;
			supp_q      <= 1'b0;
			running_q   <= 1'b0;
			onoff_arm_q <= 1'b1;
			up_arm_q    <= 1'b0;
			down_arm_q  <= 1'b0;
			pulse_arm_q <= 1'b0;
			pcount_q    <= '0;
			ptotal_q    <= '0;
			ticks_q     <= '0;
		end else if (fire2) begin
			set_q       <= n_set;
			duty_hold_q <= n_duty;
			cruise_q    <= n_cruise;
			lamp_q      <= n_lamp;
			supp_q      <= n_supp;
			running_q   <= n_run;
			onoff_arm_q <= n_onoff_arm;
			up_arm_q    <= n_up_arm;
			down_arm_q  <= n_down_arm;
			pulse_arm_q <= n_pulse_arm;
			pcount_q    <= n_pcount;
			ptotal_q    <= n_ptotal;
			ticks_q     <= n_ticks;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_en) begin
			out_v_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (fire2) begin
			duty_q    <= n_duty;
			led_q     <= n_lamp;
			active_q  <= n_cruise;
			rep_v_q   <= n_rep_v;
			rep_val_q <= n_rep_val;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {(OUT_TDATA_W-PULSE_W-SPEED_W-2)'(0), rep_val_q, active_q, led_q, duty_q};
	assign m_tuser  = rep_v_q;

	// Checks on the control and averaging logic.
`include "cruise_speed_controller_unit_assert.svh"

	`CSC_ASSERT_IMP(a_led_needs_cruise, out_v_q && led_q, active_q)
	`CSC_ASSERT_IMP(a_duty_in_range, out_v_q, duty_q <= SPEED_W'(SPEED_MAX))
	`CSC_ASSERT_IMP(a_window_in_range, 1'b1, cnt_q <= CNT_W'(AVG_LIMIT))
	`CSC_ASSERT_NXT(a_run_off_stops, fire2 && cmd_s2 == CMD_RUN_OFF, !running_q && !cruise_q)

endmodule
